@@ rtl/core/n_queens_solution_enumerator_top_assert.svh @@
// assertion macros for the n-queens enumerator
// clocked on clk, disabled while arst_n is low
`ifndef N_QUEENS_SOLUTION_ENUMERATOR_TOP_ASSERT_SVH
`define N_QUEENS_SOLUTION_ENUMERATOR_TOP_ASSERT_SVH

// general property check
`define NQSE_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold
`define NQSE_NEVER(name, cond, msg) \
	`NQSE_ASSERT(name, !(cond), msg)

`endif

@@ rtl/core/nqse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqse_pkg
// shared types and codes of the n-queens solution enumerator
// ----------------------------------------------------------------------------
package nqse_pkg;

	localparam int NQ_MAX_N     = 8;
	localparam int ROW_FIELD_W  = 4;
	localparam int PLACE_COLS   = 8;
	localparam int SIZE_W       = 4;
	localparam int PLACE_W      = ROW_FIELD_W * PLACE_COLS;
	localparam int COUNT_W      = 16;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_NEXT  = 1'b1;

	typedef enum logic [1:0] {
		RES_FOUND        = 2'd0,
		RES_EXHAUSTED    = 2'd1,
		RES_NOT_POSSIBLE = 2'd2,
		RES_STARTED      = 2'd3
	} result_t;

	// per-column cell control
	typedef struct packed {
		logic clear;
		logic place;
	} cell_ctrl_t;

endpackage

@@ rtl/core/nqse_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqse_cell
// one board column: finds the lowest free row at or above the start row,
// holds its queen row and the occupancy masks handed on to the next column
// ----------------------------------------------------------------------------
module nqse_cell
	import nqse_pkg::*;
#(
	parameter int MAX_N = NQ_MAX_N,
	parameter int COL   = 0,
	localparam int CW   = $clog2(MAX_N + 1),
	localparam int RW   = $clog2(MAX_N),
	localparam int DW   = 2 * MAX_N - 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic [CW-1:0]    start_row,
	input  logic [CW-1:0]    size,
	input  logic [MAX_N-1:0] row_in,
	input  logic [DW-1:0]    rise_in,
	input  logic [DW-1:0]    fall_in,
	output logic [MAX_N-1:0] row_out,
	output logic [DW-1:0]    rise_out,
	output logic [DW-1:0]    fall_out,
	output logic             hit,
	output logic [RW-1:0]    queen_row
);

	localparam logic [MAX_N-1:0] ONE_V = {{(MAX_N-1){1'b0}}, 1'b1};

	logic [MAX_N-1:0] free_v;
	logic [MAX_N-1:0] sel_v;
	logic [DW-1:0]    rise_add;
	logic [DW-1:0]    fall_add;
	logic [RW-1:0]    hit_row;
	logic [RW-1:0]    row_q;
	logic [MAX_N-1:0] row_out_q;
	logic [DW-1:0]    rise_out_q;
	logic [DW-1:0]    fall_out_q;

	always_comb begin
		for (int r = 0; r < MAX_N; r++) begin
			free_v[r] = !row_in[r] && !rise_in[r + COL] && !fall_in[MAX_N - 1 + COL - r]
				&& (CW'(r) >= start_row) && (CW'(r) < size);
		end
	end

	// isolate lowest free row
	assign sel_v = free_v & (~free_v + ONE_V);
	assign hit   = |free_v;

	always_comb begin
		rise_add = '0;
		fall_add = '0;
		hit_row  = '0;
		for (int r = 0; r < MAX_N; r++) begin
			if (sel_v[r]) begin
				rise_add[r + COL]           = 1'b1;
				fall_add[MAX_N - 1 + COL - r] = 1'b1;
				hit_row                     = hit_row | RW'(r);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctrl.clear) begin
			row_q <= '0;
		end else if (ctrl.place) begin
			row_q <= hit_row;
		end
	end

	// masks are only read downstream once this column holds a queen
	always_ff @(posedge clk) begin
		if (ctrl.place) begin
			row_out_q  <= row_in | sel_v;
			rise_out_q <= rise_in | rise_add;
			fall_out_q <= fall_in | fall_add;
		end
	end

	assign row_out   = row_out_q;
	assign rise_out  = rise_out_q;
	assign fall_out  = fall_out_q;
	assign queen_row = row_q;

endmodule

@@ rtl/core/n_queens_solution_enumerator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator_top
// depth-first n-queens search over a chain of column cells
// ----------------------------------------------------------------------------
// A request on the input channel (in_valid/in_stall) carries action and
// board_size. action start latches the size, clears the board and answers
// started, or not possible for sizes 0, 2, 3 and above MAX_N. action next
// resumes the search and answers with the next solution (status found, one
// queen row per 4-bit column field) or exhausted. Exactly one result comes
// out on the output channel (out_valid/out_stall) per request.
// Timing: a start, or a next with no open search, answers in the cycle after
// acceptance. A searching next resumes, then takes one search node per cycle
// (a placement or a backtrack step of the active column cell), and emits a
// solution from the emit state; exhaustion answers from the last search
// cycle.
// One request is in flight at a time; in_stall stays high while searching.
// A result held by out_stall stays in the output register and blocks new
// requests until it leaves.
// Reset clears the board, the count and the open search at once.
// ----------------------------------------------------------------------------
`include "n_queens_solution_enumerator_top_assert.svh"

module n_queens_solution_enumerator_top
	import nqse_pkg::*;
#(
	parameter int MAX_N = NQ_MAX_N
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  logic [SIZE_W-1:0]   board_size,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [PLACE_W-1:0]  placement,
	output logic [COUNT_W-1:0]  solution_count
);

	localparam int CW = $clog2(MAX_N + 1);
	localparam int RW = $clog2(MAX_N);
	localparam int DW = 2 * MAX_N - 1;
	localparam int PC = (MAX_N < PLACE_COLS) ? MAX_N : PLACE_COLS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_EMIT
	} fsm_t;

	fsm_t                 state_q;
	logic [CW-1:0]        col_q;
	logic [CW-1:0]        start_q;
	logic [CW-1:0]        n_q;
	logic                 active_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 out_valid_q;
	result_t              status_q;
	logic [PLACE_W-1:0]   placement_q;

	logic                 in_acc;
	logic                 out_free;
	logic                 size_ok;
	logic                 hit_any;
	logic [RW-1:0]        prev_row;
	logic [RW-1:0]        last_row;
	logic [PLACE_W-1:0]   place_pack;
	logic [COUNT_W-1:0]   count_inc;

	logic [MAX_N-1:0]     act_sel;
	logic [MAX_N-1:0]     prev_sel;
	logic [MAX_N-1:0]     last_sel;
	logic [MAX_N-1:0]     hits;
	logic [MAX_N-1:0]     place_v;
	logic [RW-1:0]        rows   [MAX_N];
	logic [MAX_N-1:0]     row_m  [MAX_N+1];
	logic [DW-1:0]        rise_m [MAX_N+1];
	logic [DW-1:0]        fall_m [MAX_N+1];

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;
	assign size_ok  = !(board_size inside {4'd0, 4'd2, 4'd3}) && (int'(board_size) <= MAX_N);
	assign count_inc = (count_q == '1) ? count_q : count_q + COUNT_W'(1);

	assign row_m[0]  = '0;
	assign rise_m[0] = '0;
	assign fall_m[0] = '0;

	for (genvar c = 0; c < MAX_N; c++) begin : g_cell
		cell_ctrl_t ctrl;

		assign act_sel[c]  = (col_q == CW'(c));
		assign prev_sel[c] = (col_q == CW'(c + 1));
		assign last_sel[c] = (n_q == CW'(c + 1));
		assign place_v[c]  = (state_q == S_SEARCH) && act_sel[c] && hits[c];
		assign ctrl.clear  = in_acc && (action == ACT_START);
		assign ctrl.place  = place_v[c];

		nqse_cell #(
			.MAX_N (MAX_N),
			.COL   (c)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.start_row (start_q),
			.size      (n_q),
			.row_in    (row_m[c]),
			.rise_in   (rise_m[c]),
			.fall_in   (fall_m[c]),
			.row_out   (row_m[c+1]),
			.rise_out  (rise_m[c+1]),
			.fall_out  (fall_m[c+1]),
			.hit       (hits[c]),
			.queen_row (rows[c])
		);
	end

	always_comb begin
		hit_any  = 1'b0;
		prev_row = '0;
		last_row = '0;
		for (int c = 0; c < MAX_N; c++) begin
			hit_any  = hit_any | (act_sel[c] & hits[c]);
			prev_row = prev_row | (prev_sel[c] ? rows[c] : '0);
			last_row = last_row | (last_sel[c] ? rows[c] : '0);
		end
	end

	always_comb begin
		place_pack = '0;
		for (int c = 0; c < PC; c++) begin
			if (CW'(c) < n_q) begin
				place_pack[ROW_FIELD_W*c +: ROW_FIELD_W] = ROW_FIELD_W'(rows[c]);
			end
		end
	end

	// the output register only holds a result while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			start_q     <= '0;
			n_q         <= '0;
			active_q    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= RES_FOUND;
			placement_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (action == ACT_START) begin
							col_q       <= '0;
							count_q     <= '0;
							n_q         <= CW'(board_size);
							active_q    <= size_ok;
							status_q    <= size_ok ? RES_STARTED : RES_NOT_POSSIBLE;
							placement_q <= '0;
							out_valid_q <= 1'b1;
						end else if (!active_q) begin
							status_q    <= RES_EXHAUSTED;
							placement_q <= '0;
							out_valid_q <= 1'b1;
						end else begin
							// resume: after a solution, lift the last queen and try the rows above it; else start at row 0
							if (col_q == n_q) begin
								col_q   <= n_q - CW'(1);
								start_q <= CW'(last_row) + CW'(1);
							end else begin
								start_q <= '0;
							end
							out_valid_q <= 1'b0;
							state_q     <= S_SEARCH;
						end
					end else if (!out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				S_SEARCH: begin
					if (hit_any) begin
						col_q   <= col_q + CW'(1);
						start_q <= '0;
						if (col_q + CW'(1) == n_q) begin
							state_q <= S_EMIT;
						end
					end else if (col_q == '0) begin
						if (out_free) begin
							active_q    <= 1'b0;
							status_q    <= RES_EXHAUSTED;
							placement_q <= '0;
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else begin
						col_q   <= col_q - CW'(1);
						start_q <= CW'(prev_row) + CW'(1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						count_q     <= count_inc;
						status_q    <= RES_FOUND;
						placement_q <= place_pack;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign placement      = placement_q;
	assign solution_count = count_q;

	`NQSE_ASSERT(a_one_cell_places, $onehot0(place_v), "more than one column placed at once")
	`NQSE_NEVER(a_col_in_range, active_q && (col_q > n_q), "column counter beyond board size")
	`NQSE_ASSERT(a_found_counts, (out_valid_q && status_q == RES_FOUND) |-> (count_q != '0), "zero count")
	`NQSE_ASSERT(a_search_open, (state_q == S_SEARCH) |-> active_q, "search running with no open search")

endmodule
